// File: rtl/tsp_pkg.sv
// ----------------------------------------------------------------------------
// tsp_pkg
// Shared types, codes and note tables of the tone sequence player.
// ----------------------------------------------------------------------------
package tsp_pkg;

    localparam int unsigned PWM_CLOCK_HZ        = 64000;
    localparam int unsigned MAX_SEQUENCE_LENGTH = 16;

    // divider sizing follows the PWM clock
    localparam int unsigned CLK_W = $clog2(PWM_CLOCK_HZ + 1);
    localparam int unsigned CNT_W = $clog2(CLK_W + 1);

    localparam int unsigned NOTE_COUNT = 18;

    // command codes
    localparam logic [2:0] MODE_TICK  = 3'd0;
    localparam logic [2:0] MODE_QROM  = 3'd1;
    localparam logic [2:0] MODE_QTONE = 3'd2;
    localparam logic [2:0] MODE_CONT  = 3'd3;
    localparam logic [2:0] MODE_STOP  = 3'd4;

    localparam logic [2:0] SEQ_CUSTOM = 3'd4;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'b001,
        PH_TONE  = 3'b010,
        PH_PAUSE = 3'b100
    } phase_t;

    typedef struct packed {
        logic [15:0] hz;
        logic [15:0] on_ms;
        logic [15:0] gap_ms;
    } note_t;

    typedef struct packed {
        logic capture;
        logic queue_rom;
        logic queue_custom;
        logic stop;
        logic clear_compare;
        logic set_pause;
        logic step_index;
        logic end_seq;
        logic start_note;
        logic tone_start;
        logic load_result;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [2:0] mode;
        phase_t     phase;
        logic       seq_ready;
        logic       due;
        logic       gap_zero;
        logic       last_note;
        logic       note_hz_zero;
        logic       in_hz_zero;
        logic       div_done;
        logic       out_free;
    } dp_status_t;

    function automatic logic [4:0] rom_start(input logic [1:0] sid);
        logic [4:0] r;
        unique case (sid)
            2'd0:    r = 5'd0;
            2'd1:    r = 5'd10;
            2'd2:    r = 5'd13;
            default: r = 5'd16;
        endcase
        return r;
    endfunction

    function automatic logic [4:0] rom_len(input logic [1:0] sid);
        logic [4:0] r;
        unique case (sid)
            2'd0:    r = 5'd10;
            2'd1:    r = 5'd3;
            2'd2:    r = 5'd3;
            default: r = 5'd1;
        endcase
        return r;
    endfunction

    function automatic note_t rom_note(input logic [4:0] k);
        note_t n;
        unique case (k)
            5'd0:    n = '{16'd392, 16'd150, 16'd50};
            5'd1:    n = '{16'd440, 16'd150, 16'd50};
            5'd2:    n = '{16'd392, 16'd150, 16'd50};
            5'd3:    n = '{16'd330, 16'd150, 16'd100};
            5'd4:    n = '{16'd523, 16'd200, 16'd100};
            5'd5:    n = '{16'd392, 16'd150, 16'd50};
            5'd6:    n = '{16'd440, 16'd150, 16'd50};
            5'd7:    n = '{16'd392, 16'd150, 16'd50};
            5'd8:    n = '{16'd330, 16'd150, 16'd100};
            5'd9:    n = '{16'd523, 16'd200, 16'd200};
            5'd10:   n = '{16'd523, 16'd100, 16'd50};
            5'd11:   n = '{16'd659, 16'd100, 16'd50};
            5'd12:   n = '{16'd784, 16'd150, 16'd0};
            5'd13:   n = '{16'd392, 16'd150, 16'd50};
            5'd14:   n = '{16'd330, 16'd150, 16'd50};
            5'd15:   n = '{16'd262, 16'd200, 16'd0};
            5'd16:   n = '{16'd523, 16'd50, 16'd0};
            default: n = '{16'd0, 16'd0, 16'd0};
        endcase
        return n;
    endfunction

endpackage

// File: rtl/tone_sequence_player.sv
// ----------------------------------------------------------------------------
// tone_sequence_player
// Buzzer note sequencer driving an 8-bit PWM period and 7-bit compare pair.
// ----------------------------------------------------------------------------
// Each command (tick, queue built-in sequence, queue tone, continuous tone,
// stop) yields exactly one result with the PWM period, compare and busy flag.
// Commands are handled one at a time: a plain tick, queue or stop passes
// through decode straight to the result stage; a continuous tone or a tick
// that starts or moves on to a note also waits on the bit-serial divider
// that computes the period, unless the frequency is zero. The next command
// is taken the cycle after the result is loaded, while that result may
// still wait in the output register; a new result holds the block until
// the previous one has been taken.
module tone_sequence_player
    import tsp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  mode,
    input  logic [31:0] now_ms,
    input  logic [1:0]  sequence_id,
    input  logic [15:0] frequency,
    input  logic [15:0] tone_ms,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  pwm_period,
    output logic [6:0]  pwm_compare,
    output logic        busy_res
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    tsp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    tsp_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .mode        (mode),
        .now_ms      (now_ms),
        .sequence_id (sequence_id),
        .frequency   (frequency),
        .tone_ms     (tone_ms),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pwm_period  (pwm_period),
        .pwm_compare (pwm_compare),
        .busy_res    (busy_res)
    );

endmodule

// File: rtl/tsp_div.sv
// ----------------------------------------------------------------------------
// tsp_div
// Restoring divider: PWM clock over a 16-bit frequency, one bit per cycle.
// ----------------------------------------------------------------------------
module tsp_div
    import tsp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [15:0]      divisor,
    output logic             done,
    output logic [CLK_W-1:0] quotient
);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [15:0]      rem_reg;
    logic [CLK_W-1:0] quo_reg;
    logic [15:0]      dsr_reg;

    logic [16:0] shifted;
    logic [16:0] diff;
    logic        fits;

    assign shifted = {rem_reg, quo_reg[CLK_W-1]};
    assign diff    = shifted - {1'b0, dsr_reg};
    assign fits    = shifted >= {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(CLK_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= CLK_W'(PWM_CLOCK_HZ);
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[15:0] : shifted[15:0];
            quo_reg <= {quo_reg[CLK_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: rtl/tsp_datapath.sv
// ----------------------------------------------------------------------------
// tsp_datapath
// Player state, note lookup, deadline arithmetic, PWM registers, result stage.
// ----------------------------------------------------------------------------
module tsp_datapath
    import tsp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  ctrl_cmd_t   cmd,
    output dp_status_t  status,
    input  logic [2:0]  mode,
    input  logic [31:0] now_ms,
    input  logic [1:0]  sequence_id,
    input  logic [15:0] frequency,
    input  logic [15:0] tone_ms,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  pwm_period,
    output logic [6:0]  pwm_compare,
    output logic        busy_res
);

    // captured item
    logic [2:0]  mode_reg;
    logic [31:0] now_reg;
    logic [1:0]  sid_reg;
    logic [15:0] hz_reg;
    logic [15:0] dur_reg;

    // player state
    phase_t      phase_reg;
    logic        seq_active_reg;
    logic [2:0]  active_seq_reg;
    logic [3:0]  active_len_reg;
    logic [3:0]  idx_reg;
    logic [31:0] deadline_reg;
    logic [15:0] cust_hz_reg;
    logic [15:0] cust_dur_reg;
    logic [7:0]  period_reg;
    logic [6:0]  compare_reg;

    // result stage
    logic        out_valid_reg;
    logic [7:0]  out_period_reg;
    logic [6:0]  out_compare_reg;
    logic        out_busy_reg;

    note_t            cur_note;
    logic [3:0]       idx_plus;
    logic [4:0]       qlen;
    logic [15:0]      div_divisor;
    logic             div_start;
    logic             div_done;
    logic [CLK_W-1:0] div_q;
    logic [CLK_W-1:0] q_m1;
    logic [7:0]       new_period;
    logic             busy_now;

    always_comb
    begin
        cur_note = '0;
        if (active_seq_reg == SEQ_CUSTOM)
        begin
            cur_note.hz    = cust_hz_reg;
            cur_note.on_ms = cust_dur_reg;
        end
        else if (!active_seq_reg[2] && ({1'b0, idx_reg} < rom_len(active_seq_reg[1:0])))
        begin
            cur_note = rom_note(rom_start(active_seq_reg[1:0]) + {1'b0, idx_reg});
        end
    end

    assign idx_plus = idx_reg + 4'd1;
    assign qlen     = (rom_len(sid_reg) > 5'(MAX_SEQUENCE_LENGTH)) ?
                      5'(MAX_SEQUENCE_LENGTH) : rom_len(sid_reg);

    assign div_divisor = cmd.tone_start ? hz_reg : cur_note.hz;
    assign div_start   = (cmd.start_note && (cur_note.hz != 16'd0)) ||
                         (cmd.tone_start && (hz_reg != 16'd0));

    tsp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    // period = clock/f - 1, a zero quotient wraps to the top, clamped to 1..255
    assign q_m1 = div_q - CLK_W'(1);
    always_comb
    begin
        if (div_q == '0)
            new_period = 8'd255;
        else if (q_m1 > CLK_W'(255))
            new_period = 8'd255;
        else if (q_m1 == '0)
            new_period = 8'd1;
        else
            new_period = q_m1[7:0];
    end

    assign busy_now = (phase_reg != PH_IDLE) || (seq_active_reg && (active_len_reg != 4'd0));

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg <= mode;
            now_reg  <= now_ms;
            sid_reg  <= sequence_id;
            hz_reg   <= frequency;
            dur_reg  <= tone_ms;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            seq_active_reg <= 1'b0;
            active_seq_reg <= 3'd0;
            active_len_reg <= 4'd0;
            idx_reg        <= 4'd0;
            deadline_reg   <= 32'd0;
            cust_hz_reg    <= 16'd0;
            cust_dur_reg   <= 16'd0;
            period_reg     <= 8'd255;
            compare_reg    <= 7'd0;
        end
        else
        begin
            if (cmd.queue_rom)
            begin
                active_seq_reg <= {1'b0, sid_reg};
                active_len_reg <= qlen[3:0];
                seq_active_reg <= 1'b1;
                idx_reg        <= 4'd0;
                phase_reg      <= PH_IDLE;
            end
            if (cmd.queue_custom)
            begin
                cust_hz_reg    <= hz_reg;
                cust_dur_reg   <= dur_reg;
                active_seq_reg <= SEQ_CUSTOM;
                active_len_reg <= 4'd1;
                seq_active_reg <= 1'b1;
                idx_reg        <= 4'd0;
                phase_reg      <= PH_IDLE;
            end
            if (cmd.stop)
            begin
                phase_reg      <= PH_IDLE;
                seq_active_reg <= 1'b0;
                active_len_reg <= 4'd0;
            end
            if (cmd.set_pause)
            begin
                deadline_reg <= now_reg + {16'd0, cur_note.gap_ms};
                phase_reg    <= PH_PAUSE;
            end
            if (cmd.step_index)
                idx_reg <= idx_plus;
            if (cmd.end_seq)
            begin
                phase_reg      <= PH_IDLE;
                seq_active_reg <= 1'b0;
            end
            if (cmd.start_note)
            begin
                deadline_reg <= now_reg + {16'd0, cur_note.on_ms};
                phase_reg    <= PH_TONE;
            end

            priority if (div_done)
            begin
                period_reg  <= new_period;
                compare_reg <= new_period[7:1];
            end
            else if (cmd.clear_compare ||
                     (cmd.start_note && (cur_note.hz == 16'd0)) ||
                     (cmd.tone_start && (hz_reg == 16'd0)))
            begin
                compare_reg <= 7'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load_result)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_result)
        begin
            out_period_reg  <= period_reg;
            out_compare_reg <= compare_reg;
            out_busy_reg    <= busy_now;
        end
    end

    assign status.mode         = mode_reg;
    assign status.phase        = phase_reg;
    assign status.seq_ready    = seq_active_reg && (active_len_reg != 4'd0);
    assign status.due          = now_reg >= deadline_reg;
    assign status.gap_zero     = cur_note.gap_ms == 16'd0;
    assign status.last_note    = idx_plus >= active_len_reg;
    assign status.note_hz_zero = cur_note.hz == 16'd0;
    assign status.in_hz_zero   = hz_reg == 16'd0;
    assign status.div_done     = div_done;
    assign status.out_free     = !out_valid_reg || out_ready;

    assign out_valid   = out_valid_reg;
    assign pwm_period  = out_period_reg;
    assign pwm_compare = out_compare_reg;
    assign busy_res    = out_busy_reg;

endmodule

// File: rtl/tsp_ctrl.sv
// ----------------------------------------------------------------------------
// tsp_ctrl
// Command sequencer: decodes one item, steps the player, waits on the divider.
// ----------------------------------------------------------------------------
module tsp_ctrl
    import tsp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_DECODE  = 6'b000010,
        ST_ADVANCE = 6'b000100,
        ST_START   = 6'b001000,
        ST_DIV     = 6'b010000,
        ST_RESP    = 6'b100000
    } ctrl_state_t;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                state_next = ST_RESP;
                unique case (status.mode)
                    MODE_TICK:
                    begin
                        unique case (status.phase)
                            PH_IDLE:
                            begin
                                if (status.seq_ready)
                                    state_next = ST_START;
                            end
                            PH_TONE:
                            begin
                                if (status.due)
                                begin
                                    cmd.clear_compare = 1'b1;
                                    if (status.gap_zero)
                                        state_next = ST_ADVANCE;
                                    else
                                        cmd.set_pause = 1'b1;
                                end
                            end
                            PH_PAUSE:
                            begin
                                if (status.due)
                                    state_next = ST_ADVANCE;
                            end
                            default:
                            begin
                                cmd.end_seq = 1'b0;
                            end
                        endcase
                    end
                    MODE_QROM:
                        cmd.queue_rom = 1'b1;
                    MODE_QTONE:
                        cmd.queue_custom = 1'b1;
                    MODE_CONT:
                    begin
                        cmd.stop       = 1'b1;
                        cmd.tone_start = 1'b1;
                        if (!status.in_hz_zero)
                            state_next = ST_DIV;
                    end
                    MODE_STOP:
                    begin
                        cmd.stop          = 1'b1;
                        cmd.clear_compare = 1'b1;
                    end
                    default:
                    begin
                        // unused codes leave the player state alone and only return a result
                        state_next = ST_RESP;
                    end
                endcase
            end
            ST_ADVANCE:
            begin
                cmd.step_index = 1'b1;
                if (status.last_note)
                begin
                    cmd.end_seq = 1'b1;
                    state_next  = ST_RESP;
                end
                else
                begin
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                cmd.start_note = 1'b1;
                state_next     = status.note_hz_zero ? ST_RESP : ST_DIV;
            end
            ST_DIV:
            begin
                if (status.div_done)
                    state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (status.out_free)
                begin
                    cmd.load_result = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_ready = state_reg == ST_IDLE;

endmodule

// File: rtl/tsp_checker.sv
// ----------------------------------------------------------------------------
// tsp_checker
// Port-level checks of the tone sequence player, bound to the top level.
// ----------------------------------------------------------------------------
module tsp_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [2:0]  mode,
    input logic [31:0] now_ms,
    input logic [1:0]  sequence_id,
    input logic [15:0] frequency,
    input logic [15:0] tone_ms,
    input logic        out_valid,
    input logic        out_ready,
    input logic [7:0]  pwm_period,
    input logic [6:0]  pwm_compare,
    input logic        busy_res
);

    // a waiting command holds
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(mode) && $stable(now_ms) &&
        $stable(sequence_id) && $stable(frequency) && $stable(tone_ms))
        else $error("command changed while waiting");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pwm_period) &&
        $stable(pwm_compare) && $stable(busy_res))
        else $error("result changed while stalled");

    // compare is either silent or half the period it was written with
    a_cmp_half: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pwm_compare == 7'd0) || (pwm_compare == pwm_period[7:1]))
        else $error("compare does not match period");

    a_period_nz: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pwm_period != 8'd0)
        else $error("period of zero");

endmodule

bind tone_sequence_player tsp_checker u_tsp_checker (.*);
